// ----- hw/rtl/dtlp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtlp_pkg
// Shared constants, codes and controller/datapath types of the line plotter.
// ----------------------------------------------------------------------------
package dtlp_pkg;

  // Screen and sampling geometry
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 40;
  localparam int LINE_STEPS    = 50;
  localparam int HALF_W        = SCREEN_WIDTH / 2;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(CELL_COUNT);

  // Arithmetic
  localparam int COORD_W      = 16;                // Q3.12 input coordinate
  localparam int DEPTH_W      = 16;                // stored depth
  localparam int PT_W         = 18;                // interpolated point / depth
  localparam int NUM_W        = 26;                // projection numerator
  localparam int DIV_NW       = 24;                // divider dividend/quotient
  localparam int DIV_CNT_W    = $clog2(DIV_NW + 1);
  localparam int STEP_W       = 8;                 // sample index, LINE_STEPS <= 255
  localparam int PROJ_GAIN    = 50;
  localparam int DEPTH_OFFSET = 5 * 4096;
  localparam int COUNT_W      = 6;
  localparam logic [7:0] BLANK_GLYPH = 8'h20;

  // Reciprocal of LINE_STEPS, exact for 17-bit dividends at any LINE_STEPS
  localparam int RECIP_SHIFT  = 25;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int STEP_RECIP   = (2 ** RECIP_SHIFT + LINE_STEPS - 1) / LINE_STEPS;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_INIT,        // clearing pass after reset, no result
    S_IDLE,
    S_CLEAR,
    S_SETUP,
    S_SETUP_WAIT,
    S_PROJ,
    S_PROJ_WAIT,
    S_LOOKUP,
    S_TEST,
    S_STEP,
    S_RDCELL,
    S_RDDATA,
    S_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic clr_wr;
    logic setup_start;
    logic setup_take;
    logic proj_start;
    logic rd_sample;
    logic test_wr;
    logic step;
    logic rd_cell;
    logic rd_take;
    logic out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic  in_valid;
    mode_t in_mode;
    logic  clr_last;
    logic  div_busy;
    logic  pt_vis;
    logic  on_screen;
    logic  last_sample;
    logic  out_free;
  } sts_t;

endpackage

// ----- hw/rtl/dtlp_in_if.sv -----
// ----------------------------------------------------------------------------
// dtlp_in_if
// Command channel of the line plotter: mode, segment endpoints, glyph, cell.
// ----------------------------------------------------------------------------
interface dtlp_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] start_z;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [15:0] end_z;
  logic [7:0]        glyph;
  logic [5:0]        read_row;
  logic [6:0]        read_column;

  modport source (output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  glyph, read_row, read_column, input ready);
  modport sink   (input valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  glyph, read_row, read_column, output ready);
endinterface

// ----- hw/rtl/dtlp_out_if.sv -----
// ----------------------------------------------------------------------------
// dtlp_out_if
// Result channel of the line plotter: read glyph and plotted sample count.
// ----------------------------------------------------------------------------
interface dtlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_glyph;
  logic [5:0] plotted_count;

  modport source (output valid, cell_glyph, plotted_count, input ready);
  modport sink   (input valid, cell_glyph, plotted_count, output ready);
endinterface

// ----- hw/rtl/dtlp_div.sv -----
// ----------------------------------------------------------------------------
// dtlp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtlp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [dtlp_pkg::DIV_NW-1:0]       dividend,
  input  logic [dtlp_pkg::DEPTH_W-1:0]      divisor,
  output logic                              busy,
  output logic [dtlp_pkg::DIV_NW-1:0]       quotient
);

  logic [dtlp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [dtlp_pkg::DIV_NW-1:0]    quo_r, quo_nxt;
  logic [dtlp_pkg::DEPTH_W-1:0]   rem_r, rem_nxt;
  logic [dtlp_pkg::DEPTH_W-1:0]   div_r;
  logic [dtlp_pkg::DEPTH_W:0]     trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[dtlp_pkg::DIV_NW-1]};
    quo_nxt = {quo_r[dtlp_pkg::DIV_NW-2:0], 1'b0};
    rem_nxt = trial[dtlp_pkg::DEPTH_W-1:0];
    cnt_nxt = cnt_r - 1'b1;
    if (trial >= {1'b0, div_r}) begin
      rem_nxt    = dtlp_pkg::DEPTH_W'(trial - {1'b0, div_r});
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= dtlp_pkg::DIV_CNT_W'(dtlp_pkg::DIV_NW);
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;

endmodule

// ----- hw/rtl/dtlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtlp_ctrl
// Sequencer of the line plotter: clear sweep, segment walk, cell read.
// ----------------------------------------------------------------------------
module dtlp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  dtlp_pkg::sts_t   sts,
  output dtlp_pkg::cmd_t   cmd
);

  dtlp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtlp_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtlp_pkg::S_INIT:       if (sts.clr_last) state_nxt = dtlp_pkg::S_IDLE;
      dtlp_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          case (sts.in_mode)
            dtlp_pkg::MODE_CLEAR: state_nxt = dtlp_pkg::S_CLEAR;
            dtlp_pkg::MODE_DRAW:  state_nxt = dtlp_pkg::S_SETUP;
            dtlp_pkg::MODE_READ:  state_nxt = dtlp_pkg::S_RDCELL;
            default:              state_nxt = dtlp_pkg::S_DONE;
          endcase
        end
      end
      dtlp_pkg::S_CLEAR:      if (sts.clr_last) state_nxt = dtlp_pkg::S_DONE;
      dtlp_pkg::S_SETUP:      state_nxt = dtlp_pkg::S_SETUP_WAIT;
      dtlp_pkg::S_SETUP_WAIT: if (!sts.div_busy) state_nxt = dtlp_pkg::S_PROJ;
      dtlp_pkg::S_PROJ: begin
        state_nxt = sts.pt_vis ? dtlp_pkg::S_PROJ_WAIT : dtlp_pkg::S_STEP;
      end
      dtlp_pkg::S_PROJ_WAIT:  if (!sts.div_busy) state_nxt = dtlp_pkg::S_LOOKUP;
      dtlp_pkg::S_LOOKUP: begin
        state_nxt = sts.on_screen ? dtlp_pkg::S_TEST : dtlp_pkg::S_STEP;
      end
      dtlp_pkg::S_TEST:       state_nxt = dtlp_pkg::S_STEP;
      dtlp_pkg::S_STEP: begin
        state_nxt = sts.last_sample ? dtlp_pkg::S_DONE : dtlp_pkg::S_PROJ;
      end
      dtlp_pkg::S_RDCELL:     state_nxt = dtlp_pkg::S_RDDATA;
      dtlp_pkg::S_RDDATA:     state_nxt = dtlp_pkg::S_DONE;
      dtlp_pkg::S_DONE:       if (sts.out_free) state_nxt = dtlp_pkg::S_IDLE;
      default:                state_nxt = dtlp_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.in_ready    = (state_r == dtlp_pkg::S_IDLE);
    cmd.load        = cmd.in_ready && sts.in_valid;
    cmd.clr_wr      = (state_r == dtlp_pkg::S_INIT) || (state_r == dtlp_pkg::S_CLEAR);
    cmd.setup_start = (state_r == dtlp_pkg::S_SETUP);
    cmd.setup_take  = (state_r == dtlp_pkg::S_SETUP_WAIT) && !sts.div_busy;
    cmd.proj_start  = (state_r == dtlp_pkg::S_PROJ) && sts.pt_vis;
    cmd.rd_sample   = (state_r == dtlp_pkg::S_LOOKUP) && sts.on_screen;
    cmd.test_wr     = (state_r == dtlp_pkg::S_TEST);
    cmd.step        = (state_r == dtlp_pkg::S_STEP);
    cmd.rd_cell     = (state_r == dtlp_pkg::S_RDCELL);
    cmd.rd_take     = (state_r == dtlp_pkg::S_RDDATA);
    cmd.out_load    = (state_r == dtlp_pkg::S_DONE) && sts.out_free;
  end

endmodule

// ----- hw/rtl/dtlp_dp.sv -----
// ----------------------------------------------------------------------------
// dtlp_dp
// Datapath: frame memory, segment interpolator, projection, output register.
// ----------------------------------------------------------------------------
module dtlp_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtlp_pkg::cmd_t        cmd,
  output dtlp_pkg::sts_t        sts,
  // command beat
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  input  logic signed [15:0]    in_start_x,
  input  logic signed [15:0]    in_start_y,
  input  logic signed [15:0]    in_start_z,
  input  logic signed [15:0]    in_end_x,
  input  logic signed [15:0]    in_end_y,
  input  logic signed [15:0]    in_end_z,
  input  logic [7:0]            in_glyph,
  input  logic [5:0]            in_read_row,
  input  logic [6:0]            in_read_column,
  // result beat
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_cell_glyph,
  output logic [5:0]            out_plotted_count
);

  localparam int AW = dtlp_pkg::ADDR_W;
  localparam int CW = dtlp_pkg::COORD_W;
  localparam int PW = dtlp_pkg::PT_W;
  localparam int NW = dtlp_pkg::NUM_W;
  localparam int QW = dtlp_pkg::DIV_NW;
  localparam int DW = dtlp_pkg::DEPTH_W;
  localparam int PRW = 17 + dtlp_pkg::RECIP_W;
  localparam logic signed [NW-1:0] GAIN   = NW'(dtlp_pkg::PROJ_GAIN);
  localparam logic signed [NW-1:0] HW_S   = NW'(dtlp_pkg::HALF_W);
  localparam logic signed [NW-1:0] HH_S   = NW'(dtlp_pkg::HALF_H);
  localparam logic signed [PW-1:0] DOFS   = PW'(dtlp_pkg::DEPTH_OFFSET);
  localparam logic [8:0]           STEPS9 = 9'(dtlp_pkg::LINE_STEPS);
  localparam logic [16:0]          STEPS17 = 17'(dtlp_pkg::LINE_STEPS);
  localparam logic [PRW-1:0]       RECIP  = PRW'(dtlp_pkg::STEP_RECIP);

  // Frame memory: {depth, glyph} per cell
  logic [DW+7:0] mem [dtlp_pkg::CELL_COUNT];
  logic [DW+7:0] rdata_r;
  logic [AW-1:0] mem_addr;
  logic [DW+7:0] mem_wdata;
  logic          mem_we;
  logic          mem_re;

  // Beat registers
  logic signed [CW-1:0] s_r [3];
  logic signed [CW-1:0] e_r [3];
  logic [7:0]           glyph_r;
  logic [5:0]           rrow_r;
  logic [6:0]           rcol_r;

  // Interpolator lanes: |e-s|*i/L kept as quotient and remainder
  logic                 neg_r [3];
  logic [16:0]          qd_r  [3];
  logic [7:0]           rd_r  [3];
  logic [16:0]          q_r   [3];
  logic [7:0]           r_r   [3];
  logic [dtlp_pkg::STEP_W-1:0] i_r;

  logic signed [16:0]   diff  [3];
  logic [16:0]          adiff [3];
  logic signed [PW-1:0] pt    [3];
  logic [8:0]           rsum  [3];
  logic [PRW-1:0]       prod  [3];
  logic [16:0]          rem17 [3];

  // Projection
  logic signed [PW-1:0] dep;
  logic signed [NW-1:0] col_num, row_num;
  logic [QW-1:0]        col_mag, row_mag;
  logic [DW-1:0]        d_r;
  logic                 col_neg_r, row_neg_r;
  logic                 col_ok, row_ok;
  logic [AW-1:0]        samp_addr, addr_r, cell_addr, clr_addr_r;
  logic                 cell_ok;

  // Dividers: column and row
  logic [QW-1:0] div_num   [2];
  logic [DW-1:0] div_den;
  logic          div_busy  [2];
  logic [QW-1:0] div_quo   [2];

  logic [5:0] count_r;
  logic [7:0] res_glyph_r;
  logic       out_valid_r;
  logic [7:0] out_glyph_r;
  logic [5:0] out_count_r;

  // Interpolated point of the current sample
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = 17'(e_r[k]) - 17'(s_r[k]);
      adiff[k] = diff[k][16] ? 17'(-diff[k]) : 17'(diff[k]);
      pt[k]    = neg_r[k] ? PW'(s_r[k]) - PW'({1'b0, q_r[k]})
                          : PW'(s_r[k]) + PW'({1'b0, q_r[k]});
      rsum[k]  = {1'b0, r_r[k]} + {1'b0, rd_r[k]};
      // per-step quotient by reciprocal multiply, remainder from it
      prod[k]  = PRW'(adiff[k]) * RECIP;
      rem17[k] = adiff[k] - 17'(qd_r[k] * STEPS17);
    end
  end

  // Depth and projection numerators
  always_comb begin
    dep     = pt[2] + DOFS;
    col_num = HW_S * NW'(dep) + GAIN * NW'(pt[0]);
    row_num = HH_S * NW'(dep) - GAIN * NW'(pt[1]);
    col_mag = col_num[NW-1] ? QW'(-col_num) : QW'(col_num);
    row_mag = row_num[NW-1] ? QW'(-row_num) : QW'(row_num);
  end

  // Divider operands
  always_comb begin
    div_den    = DW'(dep);
    div_num[0] = col_mag;
    div_num[1] = row_mag;
  end

  for (genvar g = 0; g < 2; g++) begin : g_div
    dtlp_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .start     (cmd.proj_start),
      .dividend  (div_num[g]),
      .divisor   (div_den),
      .busy      (div_busy[g]),
      .quotient  (div_quo[g])
    );
  end

  // Screen bounds; a negative sum truncates to zero only when below one
  always_comb begin
    col_ok    = col_neg_r ? (div_quo[0] == '0) : (div_quo[0] < QW'(dtlp_pkg::SCREEN_WIDTH));
    row_ok    = row_neg_r ? (div_quo[1] == '0) : (div_quo[1] < QW'(dtlp_pkg::SCREEN_HEIGHT));
    samp_addr = AW'(AW'(div_quo[1][7:0]) * AW'(dtlp_pkg::SCREEN_WIDTH))
              + AW'(div_quo[0][7:0]);
    cell_ok   = (9'(rrow_r) < 9'(dtlp_pkg::SCREEN_HEIGHT))
             && (9'(rcol_r) < 9'(dtlp_pkg::SCREEN_WIDTH));
    cell_addr = AW'(AW'(rrow_r) * AW'(dtlp_pkg::SCREEN_WIDTH)) + AW'(rcol_r);
  end

  // Memory port
  always_comb begin
    mem_addr  = addr_r;
    mem_wdata = {d_r, glyph_r};
    mem_we    = cmd.test_wr && (d_r > rdata_r[DW+7:8]);
    mem_re    = cmd.rd_sample || cmd.rd_cell;
    if (cmd.clr_wr) begin
      mem_addr  = clr_addr_r;
      mem_wdata = {{DW{1'b0}}, dtlp_pkg::BLANK_GLYPH};
      mem_we    = 1'b1;
    end else if (cmd.rd_sample) begin
      mem_addr  = samp_addr;
    end else if (cmd.rd_cell) begin
      mem_addr  = cell_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // Beat capture, interpolation and projection registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r[0]  <= in_start_x;
      s_r[1]  <= in_start_y;
      s_r[2]  <= in_start_z;
      e_r[0]  <= in_end_x;
      e_r[1]  <= in_end_y;
      e_r[2]  <= in_end_z;
      glyph_r <= in_glyph;
      rrow_r  <= in_read_row;
      rcol_r  <= in_read_column;
    end
    if (cmd.setup_start) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= diff[k][16];
        qd_r[k]  <= prod[k][dtlp_pkg::RECIP_SHIFT +: 17];
      end
    end
    if (cmd.setup_take) begin
      for (int k = 0; k < 3; k++) begin
        rd_r[k] <= rem17[k][7:0];
        q_r[k]  <= '0;
        r_r[k]  <= '0;
      end
      i_r <= '0;
    end
    if (cmd.step) begin
      for (int k = 0; k < 3; k++) begin
        if (rsum[k] >= STEPS9) begin
          r_r[k] <= 8'(rsum[k] - STEPS9);
          q_r[k] <= q_r[k] + qd_r[k] + 17'd1;
        end else begin
          r_r[k] <= rsum[k][7:0];
          q_r[k] <= q_r[k] + qd_r[k];
        end
      end
      i_r <= i_r + 1'b1;
    end
    if (cmd.proj_start) begin
      d_r       <= DW'(dep);
      col_neg_r <= col_num[NW-1];
      row_neg_r <= row_num[NW-1];
    end
    if (cmd.rd_sample) addr_r <= samp_addr;
  end

  // Result accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r     <= '0;
      res_glyph_r <= '0;
    end else begin
      if (mem_we && !cmd.clr_wr && (count_r != 6'h3F)) count_r <= count_r + 1'b1;
      if (cmd.rd_take) res_glyph_r <= cell_ok ? rdata_r[7:0] : 8'h00;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_glyph_r <= res_glyph_r;
      out_count_r <= count_r;
    end
  end

  // Status
  always_comb begin
    sts.in_valid    = in_valid;
    sts.in_mode     = dtlp_pkg::mode_t'(in_mode);
    sts.clr_last    = (clr_addr_r == AW'(dtlp_pkg::CELL_COUNT - 1));
    sts.div_busy    = div_busy[0] || div_busy[1];
    sts.pt_vis      = !dep[PW-1] && (dep != '0);
    sts.on_screen   = col_ok && row_ok;
    sts.last_sample = (i_r == dtlp_pkg::STEP_W'(dtlp_pkg::LINE_STEPS));
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_glyph    = out_glyph_r;
  assign out_plotted_count = out_count_r;

endmodule

// ----- hw/rtl/depth_tested_line_plotter_core.sv -----
// ----------------------------------------------------------------------------
// depth_tested_line_plotter_core
// Depth-tested perspective line plotter over an 80x40 glyph/depth frame.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   mode, start/end x y z (Q3.12), glyph, read row/column
//  out_ch   out  cell_glyph, plotted_count (one beat per command)
//
//  Draw: a setup step (step size by reciprocal multiply), then per sample a
//  projection of column and row by the serial dividers, skipped when the
//  sample is behind the eye, and a depth-tested write when it is on screen.
//  Clear: one cell per cycle. Read: the cell is read, then its glyph taken.
//  After reset a clearing pass over every cell runs with in_ch not ready.
//  A finished result waits in the output register; the next command is
//  taken meanwhile.
// ----------------------------------------------------------------------------
module depth_tested_line_plotter_core (
  input  logic        clk,
  input  logic        rst_n,
  dtlp_in_if.sink     in_ch,
  dtlp_out_if.source  out_ch
);

  dtlp_pkg::cmd_t cmd;
  dtlp_pkg::sts_t sts;

  dtlp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  dtlp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_ch.valid),
    .in_mode           (in_ch.mode),
    .in_start_x        (in_ch.start_x),
    .in_start_y        (in_ch.start_y),
    .in_start_z        (in_ch.start_z),
    .in_end_x          (in_ch.end_x),
    .in_end_y          (in_ch.end_y),
    .in_end_z          (in_ch.end_z),
    .in_glyph          (in_ch.glyph),
    .in_read_row       (in_ch.read_row),
    .in_read_column    (in_ch.read_column),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_cell_glyph    (out_ch.cell_glyph),
    .out_plotted_count (out_ch.plotted_count)
  );

  assign in_ch.ready = cmd.in_ready;

  // A result carries either a glyph or a count, never both
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cell_glyph == 8'h00 || out_ch.plotted_count == 6'd0))
    else $error("result carries both glyph and count");

  // Busy right after a command is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command taken while busy");

  // Count never exceeds the number of samples
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (int'(out_ch.plotted_count) <= dtlp_pkg::LINE_STEPS + 1))
    else $error("plotted count beyond sample count");

endmodule

// ----- tb/tb_channels.sv -----
// ----------------------------------------------------------------------------
// tb_channels
// Marker file: the channel interfaces come from the RTL tree (dtlp_in_if,
// dtlp_out_if); this file only holds the helper types of the testbench.
// ----------------------------------------------------------------------------
package tb_plot_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [7:0]         glyph;
    logic [5:0]         read_row;
    logic [6:0]         read_column;
  } cmd_beat_t;

  typedef struct packed {
    logic [7:0] cell_glyph;
    logic [5:0] plotted_count;
  } res_beat_t;
endpackage

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Regression for depth_tested_line_plotter_core. A scoreboard keeps its own
// glyph/depth frame, predicts each command's result beat, and compares the
// beats that come out, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
class plot_scoreboard;
  logic [7:0]  frame_glyph [dtlp_pkg::CELL_COUNT];
  logic [15:0] frame_depth [dtlp_pkg::CELL_COUNT];
  tb_plot_pkg::res_beat_t pending [$];
  int          errors;
  int          n_draw, n_hits;

  function void blank();
    for (int k = 0; k < dtlp_pkg::CELL_COUNT; k++) begin
      frame_glyph[k] = dtlp_pkg::BLANK_GLYPH;
      frame_depth[k] = '0;
    end
  endfunction

  function int lerp(int s, int e, int i);
    return s + ((e - s) * i) / dtlp_pkg::LINE_STEPS;
  endfunction

  // Project one sample; write it when visible and nearer
  function bit plot(int px, int py, int pz, logic [7:0] g);
    int d, col, row, idx;
    d = pz + dtlp_pkg::DEPTH_OFFSET;
    if (d <= 0) return 0;
    col = (dtlp_pkg::HALF_W * d + dtlp_pkg::PROJ_GAIN * px) / d;
    row = (dtlp_pkg::HALF_H * d - dtlp_pkg::PROJ_GAIN * py) / d;
    if (col < 0 || col >= dtlp_pkg::SCREEN_WIDTH || row < 0 ||
        row >= dtlp_pkg::SCREEN_HEIGHT) return 0;
    idx = row * dtlp_pkg::SCREEN_WIDTH + col;
    if (d <= int'(frame_depth[idx])) return 0;
    frame_glyph[idx] = g;
    frame_depth[idx] = d[15:0];
    return 1;
  endfunction

  function void note_command(tb_plot_pkg::cmd_beat_t c);
    tb_plot_pkg::res_beat_t r;
    int cnt;
    r = '0;
    cnt = 0;
    case (dtlp_pkg::mode_t'(c.mode))
      dtlp_pkg::MODE_CLEAR: blank();
      dtlp_pkg::MODE_DRAW: begin
        for (int i = 0; i <= dtlp_pkg::LINE_STEPS; i++)
          if (plot(lerp(c.start_x, c.end_x, i), lerp(c.start_y, c.end_y, i),
                   lerp(c.start_z, c.end_z, i), c.glyph) && cnt < 63)
            cnt++;
        r.plotted_count = cnt[5:0];
        n_draw++;
        if (cnt != 0) n_hits++;
      end
      dtlp_pkg::MODE_READ:
        if (c.read_row < dtlp_pkg::SCREEN_HEIGHT && c.read_column < dtlp_pkg::SCREEN_WIDTH)
          r.cell_glyph = frame_glyph[c.read_row * dtlp_pkg::SCREEN_WIDTH + c.read_column];
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(tb_plot_pkg::res_beat_t got);
    tb_plot_pkg::res_beat_t want;
    if (pending.size() == 0) begin
      report("result beat with nothing pending", 1, 0);
      return;
    end
    want = pending.pop_front();
    if (got.cell_glyph !== want.cell_glyph)
      report("cell_glyph", got.cell_glyph, want.cell_glyph);
    if (got.plotted_count !== want.plotted_count)
      report("plotted_count", got.plotted_count, want.plotted_count);
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  bit   no_idle;
  bit   hold_off;
  int   quiet_cycles;
  plot_scoreboard sb;
  tb_plot_pkg::cmd_beat_t cmd_q [$];

  dtlp_in_if  in_ch ();
  dtlp_out_if out_ch ();

  depth_tested_line_plotter_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic tb_plot_pkg::cmd_beat_t rand_cmd();
    tb_plot_pkg::cmd_beat_t c;
    int k;
    c = '0;
    k = $urandom_range(99);
    c.glyph = 8'($urandom());
    if (k < 2) c.mode = dtlp_pkg::MODE_CLEAR;
    else if (k < 4) c.mode = dtlp_pkg::MODE_NONE;
    else if (k < 50) c.mode = dtlp_pkg::MODE_READ;
    else c.mode = dtlp_pkg::MODE_DRAW;
    c.read_row = ($urandom_range(9) == 0) ? 6'($urandom())
                                          : 6'($urandom_range(dtlp_pkg::SCREEN_HEIGHT - 1));
    c.read_column = ($urandom_range(9) == 0) ? 7'($urandom())
                                             : 7'($urandom_range(dtlp_pkg::SCREEN_WIDTH - 1));
    if ($urandom_range(4) == 0) begin
      // full-range noise segment
      {c.start_x, c.start_y, c.start_z} = 48'({$urandom(), $urandom()});
      {c.end_x, c.end_y, c.end_z} = 48'({$urandom(), $urandom()});
    end else begin
      // segments that mostly land on screen
      c.start_x = 16'(int'($urandom_range(6000)) - 3000);
      c.start_y = 16'(int'($urandom_range(4000)) - 2000);
      c.start_z = 16'(int'($urandom_range(30000)) - 16000);
      c.end_x = 16'(int'($urandom_range(6000)) - 3000);
      c.end_y = 16'(int'($urandom_range(4000)) - 2000);
      c.end_z = 16'(int'($urandom_range(30000)) - 16000);
    end
    return c;
  endfunction

  function automatic tb_plot_pkg::cmd_beat_t seg(int sx, int sy, int sz, int ex, int ey,
                                                 int ez, int g);
    tb_plot_pkg::cmd_beat_t c;
    c = '0;
    c.mode = dtlp_pkg::MODE_DRAW;
    c.start_x = 16'(sx); c.start_y = 16'(sy); c.start_z = 16'(sz);
    c.end_x = 16'(ex); c.end_y = 16'(ey); c.end_z = 16'(ez);
    c.glyph = 8'(g);
    return c;
  endfunction

  function automatic tb_plot_pkg::cmd_beat_t rd(int r, int c);
    tb_plot_pkg::cmd_beat_t b;
    b = '0;
    b.mode = dtlp_pkg::MODE_READ;
    b.read_row = 6'(r);
    b.read_column = 7'(c);
    return b;
  endfunction

  // Sender: offer one beat per queued command
  task send_all();
    tb_plot_pkg::cmd_beat_t c;
    while (cmd_q.size() > 0) begin
      c = cmd_q.pop_front();
      while (!no_idle && $urandom_range(99) < 11) @(negedge clk);
      {in_ch.mode, in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x,
       in_ch.end_y, in_ch.end_z, in_ch.glyph, in_ch.read_row, in_ch.read_column} = c;
      in_ch.valid = 1;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sb.note_command(c);
      @(negedge clk);
      in_ch.valid = 0;
    end
  endtask

  // Receiver: random ready, or held low during the stall
  always @(negedge clk)
    out_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 11);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.cell_glyph, out_ch.plotted_count});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: the clearing pass, a clear command, a draw and the long stall
  // all stay within its quiet-cycle limit
  always @(posedge clk)
    if (quiet_cycles > 40000) begin
      $display("watchdog: no progress");
      $display("depth_tested_line_plotter_core regression: fail");
      $finish;
    end

  initial begin
    sb = new();
    sb.blank();
    rst_n = 0;
    no_idle = 0;
    hold_off = 0;
    in_ch.valid = 0;
    {in_ch.mode, in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x,
     in_ch.end_y, in_ch.end_z, in_ch.glyph, in_ch.read_row, in_ch.read_column} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset frame, center point, depth test, off screen, behind eye
    cmd_q.push_back(rd(0, 0));
    cmd_q.push_back(rd(63, 127));
    cmd_q.push_back(seg(0, 0, 0, 0, 0, 0, 8'h2a));
    cmd_q.push_back(rd(20, 40));
    cmd_q.push_back(seg(0, 0, -4096, 0, 0, -4096, 8'hff));
    cmd_q.push_back(rd(20, 40));
    cmd_q.push_back(seg(0, 0, 4096, 0, 0, 4096, 8'h00));
    cmd_q.push_back(rd(20, 40));
    cmd_q.push_back(seg(-32768, -32768, -32768, 32767, 32767, 32767, 8'h41));
    cmd_q.push_back(seg(32767, 32767, 32767, -32768, -32768, -32768, 8'h55));
    cmd_q.push_back(seg(-4000, 1600, 0, 4000, -1600, 0, 8'haa));
    cmd_q.push_back(seg(0, 0, -32768, 0, 0, -20480, 8'h01));
    cmd_q.push_back(seg(-32768, 0, 32767, 32767, 0, 32767, 8'h7e));
    cmd_q.push_back(rd(39, 79));
    cmd_q.push_back(rd(40, 0));
    cmd_q.push_back(rd(0, 80));
    cmd_q.push_back('{mode: dtlp_pkg::MODE_NONE, default: '1});
    cmd_q.push_back('{mode: dtlp_pkg::MODE_CLEAR, default: '0});
    cmd_q.push_back(rd(20, 40));
    send_all();

    // Random, with the long stall partway in and a stretch with no idling
    for (int n = 0; n < 850; n++) begin
      cmd_q.push_back(rand_cmd());
      if (n == 300) begin
        send_all();
        hold_off = 1;
        fork
          begin repeat (3000) @(negedge clk); hold_off = 0; end
          begin
            for (int m = 0; m < 6; m++) cmd_q.push_back(rand_cmd());
            send_all();
          end
        join
      end
      if (n == 500) begin send_all(); no_idle = 1; end
      if (n == 650) begin send_all(); no_idle = 0; end
    end
    send_all();

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d draws (%0d plotted), reads, clears, unused mode, one long stall",
             sb.n_draw, sb.n_hits);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("depth_tested_line_plotter_core regression: pass");
    else
      $display("depth_tested_line_plotter_core regression: fail");
    $finish;
  end
endmodule
